// ===== rtl/altsr_pkg.sv =====
// Package with shared constants and types for the array list table.
package altsr_pkg;
    localparam int unsigned DEFAULT_DEPTH = 64;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 7;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_REMOVE_FIRST = 3'd2;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;
    localparam logic [2:0] OP_READ_ASC = 3'd5;
    localparam logic [2:0] OP_READ_DESC = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;
endpackage

// ===== rtl/array_list_table_with_sorted_readout_unit.sv =====
// Top level of the array list table with stored-order and sorted readout.
//
// An item is given on i_opcode and i_operand_value with start high while
// busy is low. Each result is on the outputs for one cycle with o_valid high;
// o_last marks the final result of an item. The receiver cannot stall.
// With n entries stored when the item is accepted, it is handled as follows
// before the next item can be accepted:
//   append, unused opcode, readout of an empty list: answered on the accept
//   (busy stays low); search: up to n entries, one entry read per cycle;
//   remove all: n entries; remove first: up to n entries; both compact in
//   place with one read and at most one write per cycle;
//   stored-order readout: one entry per cycle, each through the memory read
//   register and the output register;
//   sorted readouts: a copy pass into a scratch memory and then one full scan
//   per output that picks the minimum (or maximum) among entries not yet
//   emitted, marked by a used flag per scratch entry.
// Each memory has one read and one write port with a registered read.
// Reset clears the entry count and the controller; memory contents are
// left as they are, and entries beyond the count are never read.
module array_list_table_with_sorted_readout_unit #(
    parameter int unsigned DEPTH = altsr_pkg::DEFAULT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_opcode,
    input  logic signed [31:0]             i_operand_value,
    output logic                           o_valid,
    output logic signed [31:0]             o_element_value,
    output logic                           o_found,
    output logic [6:0]                     o_entry_count,
    output logic [1:0]                     o_status,
    output logic                           o_last
);
    import altsr_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_COPY  = 4'd4;
    localparam logic [3:0] S_SEL   = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;

    t_value r_mem [DEPTH];
    t_value r_scr [DEPTH];
    logic [DEPTH-1:0] r_used;

    logic [3:0] r_state;
    logic [2:0] r_op;
    t_value r_key;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_rd;     // read index issued
    logic [COUNT_W-1:0] r_wr;     // write index for compaction
    logic r_pend;                 // r_rdata/r_sdata hold valid read data
    logic [COUNT_W-1:0] r_pidx;
    t_value r_rdata;
    t_value r_sdata;
    logic r_found;
    logic [COUNT_W-1:0] r_emitted;
    t_value r_best;
    logic [AW-1:0] r_bidx;
    logic r_have;

    logic mem_we;
    logic [AW-1:0] mem_wa;
    t_value mem_wd;
    logic [AW-1:0] mem_ra;
    logic scr_we;
    logic [AW-1:0] scr_wa;
    t_value scr_wd;
    logic [AW-1:0] scr_ra;

    logic better;
    logic [COUNT_W-1:0] pidx_c;
    assign pidx_c = r_pidx;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
        if (scr_we) r_scr[scr_wa] <= scr_wd;
        r_sdata <= r_scr[scr_ra];
    end

    always_comb begin
        if (r_op == OP_READ_ASC) better = r_sdata < r_best;
        else better = r_sdata > r_best;
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr[AW-1:0];
        mem_wd = r_rdata;
        mem_ra = r_rd[AW-1:0];
        scr_we = 1'b0;
        scr_wa = r_pidx[AW-1:0];
        scr_wd = r_rdata;
        scr_ra = r_rd[AW-1:0];
        if (r_state == S_IDLE && start && i_opcode == OP_APPEND &&
            r_count < COUNT_W'(DEPTH)) begin
            mem_we = 1'b1;
            mem_wa = r_count[AW-1:0];
            mem_wd = i_operand_value;
        end else if (r_state == S_SHIFT && r_pend &&
                     !(r_rdata == r_key && (r_op == OP_REMOVE_ALL || !r_found))) begin
            mem_we = 1'b1;
        end else if (r_state == S_COPY && r_pend) begin
            scr_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        o_element_value <= '0;
        o_found <= 1'b0;
        o_status <= ST_OK;
        o_last <= 1'b0;
        o_entry_count <= r_count;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend <= 1'b0;
            r_used <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (start) begin
                        r_op <= i_opcode;
                        r_key <= i_operand_value;
                        r_found <= 1'b0;
                        r_rd <= '0;
                        r_wr <= '0;
                        r_emitted <= '0;
                        r_used <= '0;
                        unique case (i_opcode) inside
                            OP_APPEND: begin
                                o_valid <= 1'b1;
                                o_last <= 1'b1;
                                if (r_count < COUNT_W'(DEPTH)) begin
                                    r_count <= r_count + 1'b1;
                                    o_entry_count <= r_count + 1'b1;
                                end else begin
                                    o_status <= ST_FULL;
                                end
                            end
                            OP_SEARCH, OP_REMOVE_FIRST: r_state <= S_SCAN;
                            OP_REMOVE_ALL: r_state <= S_SHIFT;
                            OP_READ, OP_READ_ASC, OP_READ_DESC: begin
                                if (r_count == '0) begin
                                    o_valid <= 1'b1;
                                    o_last <= 1'b1;
                                    o_status <= ST_EMPTY;
                                end else if (i_opcode == OP_READ) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_COPY;
                                end
                            end
                            default: begin
                                o_valid <= 1'b1;
                                o_last <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Find first match; for remove-first, continue as a
                    // compaction with the key dropped only once.
                    if (r_pend && r_rdata == r_key) begin
                        r_found <= 1'b1;
                        r_pend <= 1'b0;
                        if (r_op == OP_SEARCH) begin
                            r_state <= S_DONE;
                        end else begin
                            r_wr <= pidx_c;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_rd < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_rd;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    if (r_pend) begin
                        if (r_rdata == r_key && (r_op == OP_REMOVE_ALL || !r_found))
                            r_found <= 1'b1;
                        else r_wr <= r_wr + 1'b1;
                    end
                    if (r_rd < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_rd;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_count <= r_wr;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_last <= 1'b1;
                    o_found <= r_found;
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    if (r_pend) begin
                        o_valid <= 1'b1;
                        o_element_value <= r_rdata;
                        o_last <= (r_pidx + 1'b1 == r_count);
                    end
                    if (r_rd < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_rd;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) r_state <= S_IDLE;
                    end
                end
                S_COPY: begin
                    if (r_rd < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_rd;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_SEL;
                            r_rd <= '0;
                            r_have <= 1'b0;
                        end
                    end
                end
                S_SEL: begin
                    if (r_pend && !r_used[r_pidx[AW-1:0]] && (!r_have || better)) begin
                        r_have <= 1'b1;
                        r_best <= r_sdata;
                        r_bidx <= r_pidx[AW-1:0];
                    end
                    if (r_rd < r_count) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_rd;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            o_valid <= 1'b1;
                            o_element_value <= r_best;
                            o_last <= (r_emitted + 1'b1 == r_count);
                            r_used[r_bidx] <= 1'b1;
                            r_emitted <= r_emitted + 1'b1;
                            r_rd <= '0;
                            r_have <= 1'b0;
                            if (r_emitted + 1'b1 == r_count) r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
